// ===== rtl/kba_pkg.sv =====
// Shared types and constants for the keyed event burst alarm.
`default_nettype none

package kba_pkg;

  // Key and ring sizing.
  localparam int NUM_KEYS  = 16;
  localparam int KEY_BITS  = 4;
  localparam int MAX_BURST = 15;
  localparam int PTR_BITS  = 4;
  localparam int CNT_BITS  = 4;
  localparam int HIST_BITS = KEY_BITS + PTR_BITS;
  localparam int HIST_DEPTH = NUM_KEYS * (MAX_BURST + 1);
  localparam int TIME_BITS = 32;

  // Configuration register sizing and reset values.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int WINDOW_BITS   = 16;
  localparam int BURST_BITS    = 4;
  localparam int COOLDOWN_BITS = 16;
  localparam logic [WINDOW_BITS-1:0]   WINDOW_RESET   = 16'd60;
  localparam logic [BURST_BITS-1:0]    BURST_RESET    = 4'd6;
  localparam logic [COOLDOWN_BITS-1:0] COOLDOWN_RESET = 16'd900;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW   = 2'd0,
    CFG_BURST    = 2'd1,
    CFG_COOLDOWN = 2'd2
  } cfg_index_t;

  // Input transaction payload.
  typedef struct packed {
    logic [KEY_BITS-1:0]  key_index;
    logic [TIME_BITS-1:0] event_time;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [KEY_BITS-1:0] key_echo;
    logic                burst_seen;
    logic                alert;
    logic [CNT_BITS-1:0] held_events;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } kba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
  } kba_status_t;

endpackage

`default_nettype wire

// ===== rtl/kba_ctrl.sv =====
// Controller state machine: sequences lookup and update of one event.
`default_nettype none

module kba_ctrl
  import kba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire kba_status_t status,
  output kba_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Handshake and command decode.
  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd.capture = in_valid && (state == ST_IDLE);
    cmd.commit  = (state == ST_EVAL) && status.slot_free;
  end

  // Next state: wait in evaluation until the result register can take the result.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kba_dpath.sv =====
// Datapath: per-key state, event history memory, burst test and result register.
`default_nettype none

module kba_dpath
  import kba_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire kba_cmd_t                 cmd,
  output kba_status_t                   status,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_item_t                     out_data,
  input  wire logic                     cfg_valid,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  // Configuration registers.
  logic [WINDOW_BITS-1:0]   window_reg;
  logic [BURST_BITS-1:0]    burst_reg;
  logic [COOLDOWN_BITS-1:0] cooldown_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg   <= WINDOW_RESET;
      burst_reg    <= BURST_RESET;
      cooldown_reg <= COOLDOWN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW:   window_reg   <= cfg_data[WINDOW_BITS-1:0];
        CFG_BURST:    burst_reg    <= cfg_data[BURST_BITS-1:0];
        CFG_COOLDOWN: cooldown_reg <= cfg_data[COOLDOWN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Per-key state, cleared at reset.
  logic [CNT_BITS-1:0]  fill_mem [NUM_KEYS];
  logic [PTR_BITS-1:0]  ptr_mem  [NUM_KEYS];
  logic [TIME_BITS-1:0] last_mem [NUM_KEYS];

  // Event history ring per key; entries are read only after being written.
  logic [TIME_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [TIME_BITS-1:0] oldest_time;

  // Transaction captured at acceptance.
  logic [KEY_BITS-1:0]  cur_key;
  logic [TIME_BITS-1:0] cur_time;
  logic [CNT_BITS-1:0]  cur_cnt;
  logic [PTR_BITS-1:0]  cur_ptr;
  logic [TIME_BITS-1:0] cur_last;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_key     <= in_data.key_index;
      cur_time    <= in_data.event_time;
      cur_cnt     <= fill_mem[in_data.key_index];
      cur_ptr     <= ptr_mem[in_data.key_index];
      cur_last    <= last_mem[in_data.key_index];
      oldest_time <= hist_mem[{in_data.key_index, ptr_mem[in_data.key_index]}];
    end
  end

  // Burst, cooldown and trimming evaluation.
  logic                 first_event;
  logic [CNT_BITS:0]    cnt_inc;
  logic [CNT_BITS:0]    need;
  logic [CNT_BITS:0]    excess;
  logic                 window_ok;
  logic                 cooldown_ok;
  logic                 burst;
  logic                 fire;
  logic [PTR_BITS-1:0]  wr_slot;
  logic [CNT_BITS:0]    new_cnt;
  logic [PTR_BITS-1:0]  new_ptr;
  logic [TIME_BITS-1:0] new_last;

  always_comb begin
    first_event = (cur_cnt == '0);
    cnt_inc     = {1'b0, cur_cnt} + (CNT_BITS+1)'(1);
    need        = (CNT_BITS+1)'(burst_reg);
    excess      = cnt_inc - need;
    wr_slot     = cur_ptr + PTR_BITS'(cur_cnt);
    window_ok   = (cur_time - oldest_time) <= TIME_BITS'(window_reg);
    cooldown_ok = (cur_time - cur_last) >= TIME_BITS'(cooldown_reg);
    burst       = !first_event && window_ok && (cnt_inc >= need);
    fire        = burst && cooldown_ok;
    priority if (first_event) begin
      new_cnt  = cnt_inc;
      new_ptr  = cur_ptr;
      new_last = '0;
    end else if (cnt_inc > need) begin
      new_cnt  = need;
      new_ptr  = cur_ptr + excess[PTR_BITS-1:0];
      new_last = fire ? cur_time : cur_last;
    end else begin
      new_cnt  = cnt_inc;
      new_ptr  = cur_ptr;
      new_last = fire ? cur_time : cur_last;
    end
  end

  // History write on commit.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hist_mem[{cur_key, wr_slot}] <= cur_time;
    end
  end

  // Per-key state update on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        fill_mem[k] <= '0;
        ptr_mem[k]  <= '0;
        last_mem[k] <= '0;
      end
    end else if (cmd.commit) begin
      fill_mem[cur_key] <= new_cnt[CNT_BITS-1:0];
      ptr_mem[cur_key]  <= new_ptr;
      last_mem[cur_key] <= new_last;
    end
  end

  // Result register: parts the evaluation from a stalled receiver.
  assign status.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.key_echo    <= cur_key;
      out_data.burst_seen  <= burst;
      out_data.alert       <= fire;
      out_data.held_events <= new_cnt[CNT_BITS-1:0];
    end
  end

  // A commit never overwrites a result that is still waiting.
  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while result register is occupied");

  // A commit always presents a result in the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");

  // Trimming leaves at most the burst count, apart from a first event.
  a_trim_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && !first_event |-> new_cnt <= need)
    else $error("held events exceed burst count after trimming");

  // An alert is only raised together with a burst.
  a_alert_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.alert || out_data.burst_seen))
    else $error("alert without burst");

endmodule

`default_nettype wire

// ===== rtl/keyed_event_burst_alarm.sv =====
// Top level of the keyed event burst alarm.
//
// Each input transaction carries a key index and an event timestamp in
// seconds. Each input yields exactly one result transaction with the key,
// whether a burst was seen, whether an alert fired, and the number of event
// times held for the key after trimming.
// Configuration registers (window, burst count, cooldown) are written through
// the cfg channel, which is always ready; write them only while the block is idle.
// An accepted input is registered, evaluated, and its result is presented from the
// output register. A new event is taken only after the last one is committed, due to
// the read-modify-write of the per-key history memory (read at accept, write at eval).
// When the receiver stalls, one finished result waits in the output register
// and the next input is still accepted; its evaluation then holds until the
// output register frees up.
// Reset clears the configuration to its defaults and the per-key fill counts,
// pointers and last-alert times; it takes effect with no clearing pass. History
// entries need no reset since they are read only after written.
`default_nettype none

module keyed_event_burst_alarm
  import kba_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_item_t                     out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  kba_cmd_t    cmd;
  kba_status_t status;

  // Configuration writes complete immediately.
  assign cfg_ready = 1'b1;

  kba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kba_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/keyed_event_burst_alarm_tb.sv =====
// Self-checking testbench for the keyed event burst alarm.
`timescale 1ns / 100ps

module keyed_event_burst_alarm_tb
  import kba_pkg::*;
;

  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_EVENTS  = 125;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RING_SIZE     = MAX_BURST + 1;

  // Tracks per-key event history and holds the alarm results still owed by the block.
  class burst_tracker;
    logic [TIME_BITS-1:0]     ring [NUM_KEYS][RING_SIZE];
    int unsigned              held [NUM_KEYS];
    int unsigned              oldest [NUM_KEYS];
    logic [TIME_BITS-1:0]     last_alert [NUM_KEYS];
    logic [WINDOW_BITS-1:0]   window;
    logic [BURST_BITS-1:0]    need;
    logic [COOLDOWN_BITS-1:0] cooldown;
    out_item_t                alarms_due [$];
    int                       mismatches;

    function new();
      for (int k = 0; k < NUM_KEYS; k++) begin
        held[k] = 0;
        oldest[k] = 0;
        last_alert[k] = '0;
      end
      window = WINDOW_RESET;
      need = BURST_RESET;
      cooldown = COOLDOWN_RESET;
      mismatches = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        CFG_WINDOW: begin
          window = value[WINDOW_BITS-1:0];
        end
        CFG_BURST: begin
          need = value[BURST_BITS-1:0];
        end
        CFG_COOLDOWN: begin
          cooldown = value[COOLDOWN_BITS-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int outstanding();
      return alarms_due.size();
    endfunction

    // Work out the alarm result of one accepted event and update the key's state.
    function void record_event(in_item_t ev);
      int unsigned          k;
      int unsigned          count;
      int unsigned          ptr;
      logic [TIME_BITS-1:0] now;
      out_item_t            res;
      k = ev.key_index;
      now = ev.event_time;
      res = '0;
      res.key_echo = ev.key_index;
      count = (held[k] > MAX_BURST) ? MAX_BURST : held[k];
      ptr = oldest[k];
      ring[k][(ptr + count) % RING_SIZE] = now;
      count++;
      if (count == 1) begin
        // A key's first event only starts its history.
        last_alert[k] = '0;
        held[k] = 1;
        oldest[k] = ptr;
        res.held_events = CNT_BITS'(1);
      end else begin
        // Differences wrap at the time width, so a burst may straddle the wrap point.
        if ((now - ring[k][ptr]) <= window && count >= need) begin
          res.burst_seen = 1'b1;
          if ((now - last_alert[k]) >= cooldown) begin
            res.alert = 1'b1;
            last_alert[k] = now;
          end
        end
        // Drop the oldest times until only the burst count remains.
        while (count > need) begin
          ptr = (ptr + 1) % RING_SIZE;
          count--;
        end
        held[k] = count;
        oldest[k] = ptr;
        res.held_events = CNT_BITS'(count);
      end
      alarms_due = {alarms_due, res};
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Compare one result transaction with the oldest alarm still owed.
    function void check_result(out_item_t got);
      out_item_t want;
      if (alarms_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = alarms_due.pop_front();
      compare_field("key_echo", 8'(want.key_echo), 8'(got.key_echo));
      compare_field("burst_seen", 8'(want.burst_seen), 8'(got.burst_seen));
      compare_field("alert", 8'(want.alert), 8'(got.alert));
      compare_field("held_events", 8'(want.held_events), 8'(got.held_events));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_ready;
  out_item_t                out_data;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  burst_tracker         tracker;
  bit                   in_steady;
  bit                   out_steady;
  bit                   hold_request;
  int                   quiet_cycles;
  logic [TIME_BITS-1:0] key_clock [NUM_KEYS];

  keyed_event_burst_alarm u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Extremes, small values that make bursts likely, or anything up to the top.
  function automatic logic [15:0] pick_setting(logic [15:0] top, logic [15:0] typical);
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return top;
    if (r < 4) return 16'($urandom_range(0, typical));
    return 16'($urandom_range(0, top));
  endfunction

  // Offer one event transaction and wait until the block takes it.
  task automatic send_event(logic [KEY_BITS-1:0] key, logic [TIME_BITS-1:0] stamp);
    in_item_t ev;
    int       gap;
    ev.key_index = key;
    ev.event_time = stamp;
    gap = in_steady ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    tracker.record_event(ev);
  endtask

  // One register write transaction; valid is left high for the next one.
  task automatic put_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, value);
  endtask

  task automatic apply_settings(logic [15:0] win, logic [3:0] burst, logic [15:0] cool);
    put_reg(CFG_WINDOW, win);
    // Upper bits of the burst register write are don't-care.
    put_reg(CFG_BURST, {12'($urandom()), burst});
    put_reg(CFG_COOLDOWN, cool);
    cfg_valid <= 1'b0;
  endtask

  // Let every owed result come back, then give the pipeline time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result checking on every accepted result transaction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_result(out_data);
    end
  end

  // Watchdog: the run ends if no transaction is accepted for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    int run;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = out_steady ? 0 : idle_cycles();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
    end
  end

  // Stimulus: directed events first, then random phases under changing settings.
  initial begin
    int          hot_base;
    int          r;
    int unsigned key;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WINDOW;
    cfg_data = '0;
    in_steady = 1'b0;
    out_steady = 1'b0;
    hold_request = 1'b0;
    quiet_cycles = 0;
    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: six events within a minute raise a burst with an alert; the
    // seventh, seventy seconds after the oldest held time, misses the window.
    for (int i = 0; i < 6; i++) begin
      send_event(4'd7, 32'(1000 + 10 * i));
    end
    send_event(4'd7, 32'd1070);
    settle();

    // Burst of two: cooldown blocking, window miss, time extremes and wrap.
    apply_settings(16'd10, 4'd2, 16'd5);
    send_event(4'd0, 32'd0);
    send_event(4'd0, 32'd0);
    send_event(4'd0, 32'd8);
    send_event(4'd0, 32'd30);
    send_event(4'd15, 32'hFFFF_FFF8);
    send_event(4'd15, 32'hFFFF_FFFF);
    send_event(4'd15, 32'h0000_0002);
    send_event(4'd15, 32'h0000_0004);
    settle();

    // Burst count of zero empties the ring, so the third event starts over.
    apply_settings(16'd0, 4'd0, 16'd0);
    send_event(4'd3, 32'd100);
    send_event(4'd3, 32'd100);
    send_event(4'd3, 32'd105);
    settle();

    for (int k = 0; k < NUM_KEYS; k++) begin
      key_clock[k] = 32'($urandom_range(0, 1000));
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(16'd0, 4'd15, 16'hFFFF);
        1: apply_settings(16'hFFFF, 4'd1, 16'd0);
        2: apply_settings(16'd30, 4'd0, 16'd20);
        default: apply_settings(pick_setting(16'hFFFF, 16'd80), 4'(pick_setting(16'd15, 16'd15)),
                                pick_setting(16'hFFFF, 16'd60));
      endcase
      in_steady = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      // In one phase the receiver holds off while events keep coming.
      if (phase == 4) begin
        in_steady = 1'b1;
        out_steady = 1'b0;
        hold_request = 1'b1;
      end
      hot_base = $urandom_range(0, NUM_KEYS - 4);
      for (int k = 0; k < NUM_KEYS; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          key_clock[k] = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
        end
      end
      for (int i = 0; i < PHASE_EVENTS; i++) begin
        key = ($urandom_range(0, 9) < 7) ? hot_base + $urandom_range(0, 3)
                                         : $urandom_range(0, NUM_KEYS - 1);
        // Mostly close spacing per key; a few jumps and arbitrary times.
        r = $urandom_range(0, 99);
        if (r < 55) begin
          key_clock[key] = key_clock[key] + 32'($urandom_range(0, 3));
        end else if (r < 80) begin
          key_clock[key] = key_clock[key] + 32'($urandom_range(0, 40));
        end else if (r < 95) begin
          key_clock[key] = key_clock[key] + 32'($urandom_range(0, 3000));
        end else begin
          key_clock[key] = $urandom();
        end
        send_event(KEY_BITS'(key), key_clock[key]);
      end
      settle();
    end

    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
